// ----- sv/sds_pkg.sv -----
// Package for the SPH density summation block: widths, constants, opcode
// and state enums, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package sds_pkg;

  // Fixed point format and field widths.
  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_W         = 32;
  localparam int REG_W         = 31;
  localparam int SUM_W         = 48;
  localparam int DIST_W        = 33;

  // Width of both operands of the shared multiplier.
  localparam int MUL_W         = 34;

  // floor(v / 3) equals (v * DIV3_MUL) >> DIV3_SH for every v below 2^32.
  localparam int               DIV3_SH  = 34;
  localparam logic [MUL_W-1:0] DIV3_MUL = 34'h1_5555_5556;

  // The density product splits the sum at this bit.
  localparam int SPLIT = 24;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Reset value of the configuration registers (1.0 in unsigned Q15.16).
  localparam logic [REG_W-1:0] REG_RESET = 31'd65536;

  // Configuration register indexes.
  localparam int                CFG_IDX_W      = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SMOOTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS       = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QMUL,
    OP_SQ,
    OP_CUBE,
    OP_WMUL,
    OP_DIV3,
    OP_ACC,
    OP_MHI,
    OP_MLO,
    OP_FIN
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QMUL,
    ST_SQ,
    ST_CUBE,
    ST_WMUL,
    ST_DIV3,
    ST_ACC,
    ST_MHI,
    ST_MLO,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic far;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/sds_if.sv -----
// Channel interfaces of the SPH density summation block: neighbor pairs in,
// densities out, and the configuration write channel. Depends on sds_pkg.
`default_nettype none

interface sds_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [sds_pkg::POS_W-1:0] particle_pos;
  logic signed [sds_pkg::POS_W-1:0] neighbor_pos;
  logic                             last_neighbor;

  modport source (output valid, particle_pos, neighbor_pos, last_neighbor, input ready);
  modport sink   (input valid, particle_pos, neighbor_pos, last_neighbor, output ready);
endinterface

interface sds_out_if;
  logic                      valid;
  logic                      ready;
  logic [sds_pkg::SUM_W-1:0] density;
  logic                      empty_sum;

  modport source (output valid, density, empty_sum, input ready);
  modport sink   (input valid, density, empty_sum, output ready);
endinterface

interface sds_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sds_pkg::CFG_IDX_W-1:0] index;
  logic [sds_pkg::REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/sds_ctrl.sv -----
// Controller of the SPH density summation block: sequences the shared
// multiplier through the kernel steps. Depends on sds_pkg.
`default_nettype none

module sds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sds_pkg::dp_status_t status_i,
  output sds_pkg::dp_cmd_t    cmd_o
);

  sds_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sds_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sds_pkg::ST_IDLE: if (in_valid_i) state_d = sds_pkg::ST_QMUL;
      sds_pkg::ST_QMUL: state_d = sds_pkg::ST_SQ;
      // A pair beyond 2h contributes nothing; skip the polynomial.
      sds_pkg::ST_SQ:   state_d = status_i.far ? sds_pkg::ST_ACC : sds_pkg::ST_CUBE;
      sds_pkg::ST_CUBE: state_d = sds_pkg::ST_WMUL;
      sds_pkg::ST_WMUL: state_d = sds_pkg::ST_DIV3;
      sds_pkg::ST_DIV3: state_d = sds_pkg::ST_ACC;
      sds_pkg::ST_ACC:  state_d = status_i.last ? sds_pkg::ST_MHI : sds_pkg::ST_IDLE;
      sds_pkg::ST_MHI:  state_d = sds_pkg::ST_MLO;
      sds_pkg::ST_MLO:  state_d = sds_pkg::ST_FIN;
      sds_pkg::ST_FIN:  if (status_i.out_free) state_d = sds_pkg::ST_IDLE;
      default:          state_d = sds_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = sds_pkg::OP_NONE;
    unique case (state_q)
      sds_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = sds_pkg::OP_LOAD;
      end
      sds_pkg::ST_QMUL: cmd_o.op = sds_pkg::OP_QMUL;
      sds_pkg::ST_SQ:   cmd_o.op = sds_pkg::OP_SQ;
      sds_pkg::ST_CUBE: cmd_o.op = sds_pkg::OP_CUBE;
      sds_pkg::ST_WMUL: cmd_o.op = sds_pkg::OP_WMUL;
      sds_pkg::ST_DIV3: cmd_o.op = sds_pkg::OP_DIV3;
      sds_pkg::ST_ACC:  cmd_o.op = sds_pkg::OP_ACC;
      sds_pkg::ST_MHI:  cmd_o.op = sds_pkg::OP_MHI;
      sds_pkg::ST_MLO:  cmd_o.op = sds_pkg::OP_MLO;
      sds_pkg::ST_FIN:  cmd_o.op = sds_pkg::OP_FIN;
      default:          cmd_o.op = sds_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/sds_datapath.sv -----
// Datapath of the SPH density summation block: configuration registers,
// shared multiplier, kernel registers, sum and output register. Depends on sds_pkg.
`default_nettype none

module sds_datapath #(
  parameter int FRAC_BITS = sds_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sds_pkg::dp_cmd_t                 cmd_i,
  output sds_pkg::dp_status_t              status_o,
  input  logic signed [sds_pkg::POS_W-1:0] particle_pos_i,
  input  logic signed [sds_pkg::POS_W-1:0] neighbor_pos_i,
  input  logic                             last_neighbor_i,
  input  logic                             cfg_we_i,
  input  logic [sds_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sds_pkg::REG_W-1:0]        cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sds_pkg::SUM_W-1:0]        density_o,
  output logic                             empty_sum_o
);

  localparam int F     = FRAC_BITS;
  localparam int MW    = sds_pkg::MUL_W;
  localparam int PW    = 2 * MW;
  localparam int SW    = sds_pkg::SUM_W;
  localparam int HW    = sds_pkg::REG_W + sds_pkg::SPLIT;
  localparam int SH    = sds_pkg::SPLIT - F;
  localparam int QFW   = PW - F;

  localparam logic [F+1:0]   ONE_Q  = (F+2)'(1) << F;
  localparam logic [F+1:0]   TWO_Q  = (F+2)'(1) << (F + 1);
  localparam logic [QFW-1:0] QF_TWO = QFW'(1) << (F + 1);
  localparam logic [HW-1:0]  HI_LIM = HW'(sds_pkg::SUM_MAX >> SH);

  // Configuration. The smoothing length itself is not needed: the kernel
  // works from its reciprocal alone.
  logic [sds_pkg::REG_W-1:0] inv_q, mass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q  <= sds_pkg::REG_RESET;
      mass_q <= sds_pkg::REG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sds_pkg::CFG_SMOOTH:     ;
        sds_pkg::CFG_INV_SMOOTH: inv_q  <= cfg_data_i;
        sds_pkg::CFG_MASS:       mass_q <= cfg_data_i;
        default:                 ;
      endcase
    end
  end

  // Working registers.
  logic [sds_pkg::DIST_W-1:0] r_q;
  logic                       last_q, far_q, near_q;
  logic [F+1:0]               q_q;
  logic [F:0]                 x_q, x2_q, f_q;
  logic [31:0]                v_q, w_q;
  logic [HW-1:0]              hi_q, lo_q;
  logic [SW-1:0]              sum_q, sum_d;
  logic                       out_valid_q;
  logic [SW-1:0]              density_q;
  logic                       empty_q;

  // Shared multiplier.
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;

  // Distance and step values.
  logic signed [sds_pkg::DIST_W-1:0] dx;
  logic [sds_pkg::DIST_W-1:0]        r_d;
  logic [QFW-1:0]                    qfull;
  logic                              near;
  logic [F+1:0]                      tdiff;
  logic [F:0]                        x_d, x3;
  logic [F+1:0]                      tri2, tri3, pos, sub;
  logic [F:0]                        f_d;
  logic [SW:0]                       sum_ext;
  logic [63:0]                       hs, ls, xsum;
  logic                              hi_big;
  logic [SW-1:0]                     dens_d;
  logic                              out_free, fin_load;

  assign dx  = sds_pkg::DIST_W'(neighbor_pos_i) - sds_pkg::DIST_W'(particle_pos_i);
  assign r_d = dx[sds_pkg::DIST_W-1] ? sds_pkg::DIST_W'(-dx) : sds_pkg::DIST_W'(dx);

  // Region split: the first branch uses q itself, the second 2 - q.
  assign near  = q_q <= ONE_Q;
  assign tdiff = TWO_Q - q_q;
  assign x_d   = near ? q_q[F:0] : tdiff[F:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      sds_pkg::OP_QMUL: begin
        mul_a = MW'(r_q);
        mul_b = MW'(inv_q);
      end
      sds_pkg::OP_SQ: begin
        mul_a = MW'(x_d);
        mul_b = MW'(x_d);
      end
      sds_pkg::OP_CUBE: begin
        mul_a = MW'(x2_q);
        mul_b = MW'(x_q);
      end
      sds_pkg::OP_WMUL: begin
        mul_a = MW'(f_q);
        mul_b = MW'(inv_q);
      end
      sds_pkg::OP_DIV3: begin
        mul_a = MW'(v_q);
        mul_b = sds_pkg::DIV3_MUL;
      end
      sds_pkg::OP_MHI: begin
        mul_a = MW'(mass_q);
        mul_b = MW'(sum_q[SW-1:sds_pkg::SPLIT]);
      end
      sds_pkg::OP_MLO: begin
        mul_a = MW'(mass_q);
        mul_b = MW'(sum_q[sds_pkg::SPLIT-1:0]);
      end
      default: ;
    endcase
  end

  assign prod  = PW'(mul_a) * PW'(mul_b);
  assign qfull = prod[PW-1:F];
  assign x3    = prod[2*F:F];

  // Polynomial from q^2 and q^3; the result never exceeds 1.0.
  assign tri2 = {1'b0, x2_q} + {x2_q, 1'b0};
  assign tri3 = {1'b0, x3} + {x3, 1'b0};
  assign sub  = {1'b0, tri2[F+1:1]};
  assign pos  = ONE_Q + {2'b00, tri3[F+1:2]};

  always_comb begin
    if (near_q) begin
      f_d = (pos > sub) ? F'(0) + (F+1)'(pos - sub) : '0;
    end else begin
      f_d = x3 >> 2;
    end
  end

  assign sum_ext = {1'b0, sum_q} + (SW+1)'(w_q);
  assign sum_d   = sum_ext[SW] ? sds_pkg::SUM_MAX : sum_ext[SW-1:0];

  // Density: mass times the sum, formed from two partial products.
  assign hi_big = hi_q > HI_LIM;
  assign hs     = 64'(hi_q) << SH;
  assign ls     = 64'(lo_q) >> F;
  assign xsum   = hs + ls;
  assign dens_d = (hi_big || (xsum > 64'(sds_pkg::SUM_MAX))) ? sds_pkg::SUM_MAX
                                                              : xsum[SW-1:0];

  assign out_free = !out_valid_q || out_ready_i;
  assign fin_load = (cmd_i.op == sds_pkg::OP_FIN) && out_free;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sds_pkg::OP_LOAD: begin
        r_q    <= r_d;
        last_q <= last_neighbor_i;
      end
      sds_pkg::OP_QMUL: begin
        far_q <= qfull > QF_TWO;
        q_q   <= qfull[F+1:0];
        w_q   <= '0;
      end
      sds_pkg::OP_SQ: begin
        near_q <= near;
        x_q    <= x_d;
        x2_q   <= prod[2*F:F];
      end
      sds_pkg::OP_CUBE: f_q <= f_d;
      sds_pkg::OP_WMUL: v_q <= prod[F+30:F-1];
      sds_pkg::OP_DIV3: w_q <= prod[sds_pkg::DIV3_SH+31:sds_pkg::DIV3_SH];
      sds_pkg::OP_MHI:  hi_q <= prod[HW-1:0];
      sds_pkg::OP_MLO:  lo_q <= prod[HW-1:0];
      default: ;
    endcase
    if (fin_load) begin
      density_q <= dens_d;
      empty_q   <= sum_q == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == sds_pkg::OP_ACC) begin
        sum_q <= sum_d;
      end else if (fin_load) begin
        sum_q <= '0;
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.far      = far_q;
  assign status_o.last     = last_q;
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign density_o   = density_q;
  assign empty_sum_o = empty_q;

  // The sum starts over once a density has been handed to the output stage.
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> sum_q == '0)
    else $error("kernel sum not cleared after a density was issued");

  // The reciprocal multiply must give exactly floor(v / 3).
  a_div3_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == sds_pkg::OP_DIV3 |=>
      (35'(w_q) * 35'd3 <= 35'(v_q)) && (35'(v_q) - 35'(w_q) * 35'd3 < 35'd3))
    else $error("division by three is off");

  // The kernel polynomial stays within [0, 1].
  a_f_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == sds_pkg::OP_CUBE |=> (F+2)'(f_q) <= ONE_Q)
    else $error("kernel polynomial above one");

  // An empty sum can only produce a zero density.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && empty_q) |-> density_q == '0)
    else $error("empty sum with nonzero density");

endmodule

`default_nettype wire

// ----- sv/sph_density_summation_unit.sv -----
// Top level of the SPH density summation block (1D cubic spline kernel).
// Depends on sds_pkg, sds_if, sds_ctrl and sds_datapath.
//
//   Channel  Dir  Handshake     Beat contents
//   in_i     in   valid/ready   particle_pos, neighbor_pos, last_neighbor
//   out_o    out  valid/ready   density, empty_sum
//   cfg_i    in   valid/ready   index, data (register write)
//
// Each neighbor pair runs through one shared multiplier, one product per
// cycle; a pair beyond 2h skips the remaining kernel steps, and the
// last_neighbor pair also forms the density (plus any wait for the output
// register to free up). The multiplier is the resource that sets the pace.
// Reset clears the kernel sum, the output register and the controller, and
// loads 1.0 into the registers; no clearing pass follows. The output
// register lets the next pair be accepted while a density waits to be taken.
`default_nettype none

module sph_density_summation_unit #(
  parameter int FRAC_BITS = sds_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sds_in_if.sink    in_i,
  sds_out_if.source out_o,
  sds_cfg_if.sink   cfg_i
);

  sds_pkg::dp_cmd_t    cmd;
  sds_pkg::dp_status_t status;
  logic                in_ready;

  // Configuration writes are always taken, unchecked; the user sends them only while idle.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  sds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sds_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .particle_pos_i  (in_i.particle_pos),
    .neighbor_pos_i  (in_i.neighbor_pos),
    .last_neighbor_i (in_i.last_neighbor),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .density_o       (out_o.density),
    .empty_sum_o     (out_o.empty_sum)
  );

endmodule

`default_nettype wire
